### rtl/core/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types and constants of the polar Gaussian sample generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

    // Configuration register indexes.
    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_STD  = 1'b1;

    localparam logic signed [23:0] MEAN_RESET = 24'sd0;
    localparam logic [23:0]        STD_RESET  = 24'd4096;

    // Squaring steps of the logarithm, steps of the ratio divider and of the square root.
    localparam int LOG_STEPS  = 30;
    localparam int DIV_STEPS  = 33;
    localparam int ROOT_STEPS = 32;

    // ln(2) with 32 fraction bits.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // One item between the front end and the end of the divider chain.
    typedef struct packed {
        logic        neg1;
        logic        neg2;
        logic [61:0] w;
        logic [5:0]  n;
        logic [30:0] m;
        logic [29:0] frac;
        logic [61:0] rem1;
        logic [61:0] rem2;
        logic [32:0] q1;
        logic [32:0] q2;
    } t_item;

    // One item in the square root chain.
    typedef struct packed {
        logic        neg1;
        logic        neg2;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] r1;
        logic [63:0] r2;
    } t_root;

endpackage

### rtl/core/gpg_front.sv
// ----------------------------------------------------------------------------
// gpg_front
// Maps the uniform words, forms w, rejects pairs on or outside the unit circle or
// at its center and normalizes w for the logarithm.
// ----------------------------------------------------------------------------
module gpg_front #(
    parameter int UB = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [UB-1:0]  i_ua,
    input  logic [UB-1:0]  i_ub,
    output logic           o_vld,
    output gpg_pkg::t_item o_item
);
    import gpg_pkg::*;

    localparam int F  = (UB > 30) ? 30 : UB;
    localparam int SH = UB - F;
    localparam logic [F+1:0] HALF  = (F+2)'(1) << F;
    localparam logic [61:0]  W_LIM = 62'(1) << (2 * F);

    logic [UB:0]  u2a, u2b, sa, sb;
    logic signed [F+1:0] da, db, na, nb;
    logic [30:0]  n_ad1, n_ad2;
    logic [61:0]  n_w;
    logic [5:0]   n_n;
    logic [30:0]  n_m;

    logic        r_v0, r_v1, r_v2, r_v3, r_v4;
    logic        r_neg1_0, r_neg2_0, r_neg1_1, r_neg2_1, r_neg1_2, r_neg2_2;
    logic        r_neg1_3, r_neg2_3;
    logic [30:0] r_ad1, r_ad2;
    logic [60:0] r_sq1, r_sq2, r_sq1_2, r_sq2_2, r_sq1_3, r_sq2_3;
    logic [61:0] r_w2, r_w3;
    logic [5:0]  r_n3;
    t_item       r_item;

    always_comb begin
        u2a = {i_ua, 1'b0};
        u2b = {i_ub, 1'b0};
        sa  = u2a >> SH;
        sb  = u2b >> SH;
        da  = $signed({1'b0, sa[F:0]}) - $signed(HALF);
        db  = $signed({1'b0, sb[F:0]}) - $signed(HALF);
        na  = -da;
        nb  = -db;
        n_ad1 = 31'(da[F+1] ? na[F:0] : da[F:0]);
        n_ad2 = 31'(db[F+1] ? nb[F:0] : db[F:0]);
    end

    assign n_w = 62'(r_sq1) + 62'(r_sq2);

    always_comb begin
        n_n = '0;
        for (int i = 0; i < 62; i++) begin
            if (r_w2[i]) n_n = 6'(i);
        end
    end

    always_comb begin
        if (r_n3 <= 6'd30) begin
            n_m = 31'(r_w3 << (6'd30 - r_n3));
        end else begin
            n_m = 31'(r_w3 >> (r_n3 - 6'd30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            // A pair on or outside the circle, or at its center, is dropped here.
            r_v2 <= r_v1 && (n_w != 62'd0) && (n_w < W_LIM);
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ad1    <= n_ad1;
            r_ad2    <= n_ad2;
            r_neg1_0 <= da[F+1];
            r_neg2_0 <= db[F+1];
            r_sq1    <= 61'(62'(r_ad1) * 62'(r_ad1));
            r_sq2    <= 61'(62'(r_ad2) * 62'(r_ad2));
            r_neg1_1 <= r_neg1_0;
            r_neg2_1 <= r_neg2_0;
            r_w2     <= n_w;
            r_sq1_2  <= r_sq1;
            r_sq2_2  <= r_sq2;
            r_neg1_2 <= r_neg1_1;
            r_neg2_2 <= r_neg2_1;
            r_w3     <= r_w2;
            r_n3     <= n_n;
            r_sq1_3  <= r_sq1_2;
            r_sq2_3  <= r_sq2_2;
            r_neg1_3 <= r_neg1_2;
            r_neg2_3 <= r_neg2_2;
            r_item.neg1 <= r_neg1_3;
            r_item.neg2 <= r_neg2_3;
            r_item.w    <= r_w3;
            r_item.n    <= r_n3;
            r_item.m    <= n_m;
            r_item.frac <= '0;
            r_item.rem1 <= 62'(r_sq1_3);
            r_item.rem2 <= 62'(r_sq2_3);
            r_item.q1   <= '0;
            r_item.q2   <= '0;
        end
    end

    assign o_vld  = r_v4;
    assign o_item = r_item;

endmodule

### rtl/core/gpg_step.sv
// ----------------------------------------------------------------------------
// gpg_step
// One stage of the iteration chain: one squaring step of the logarithm (only in
// stages below LOG_STEPS) and one restoring division step for each coordinate.
// ----------------------------------------------------------------------------
module gpg_step #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  gpg_pkg::t_item i_item,
    output logic           o_vld,
    output gpg_pkg::t_item o_item
);
    import gpg_pkg::*;

    logic [61:0] p;
    logic [31:0] ms;
    logic [61:0] rs1, rs2;
    t_item       n_item;
    logic        r_vld;
    t_item       r_item;

    always_comb begin
        n_item = i_item;
        p  = 62'(i_item.m) * 62'(i_item.m);
        ms = p[61:30];
        if (STEP < LOG_STEPS) begin
            n_item.m    = ms[31] ? ms[31:1] : ms[30:0];
            n_item.frac = {i_item.frac[28:0], ms[31]};
        end
        // The first division step compares without a shift.
        rs1 = (STEP == 0) ? i_item.rem1 : {i_item.rem1[60:0], 1'b0};
        rs2 = (STEP == 0) ? i_item.rem2 : {i_item.rem2[60:0], 1'b0};
        n_item.rem1 = (rs1 >= i_item.w) ? rs1 - i_item.w : rs1;
        n_item.rem2 = (rs2 >= i_item.w) ? rs2 - i_item.w : rs2;
        n_item.q1   = {i_item.q1[31:0], rs1 >= i_item.w};
        n_item.q2   = {i_item.q2[31:0], rs2 >= i_item.w};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

### rtl/core/gpg_tail.sv
// ----------------------------------------------------------------------------
// gpg_tail
// Turns the logarithm into -2 ln w and forms the squared outputs y^2.
// ----------------------------------------------------------------------------
module gpg_tail #(
    parameter int FRAC_X = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  gpg_pkg::t_item i_item,
    output logic           o_vld,
    output gpg_pkg::t_root o_root
);
    import gpg_pkg::*;

    localparam logic [5:0] TWO_F = 6'(2 * FRAC_X);

    logic [36:0] n_t;
    logic [62:0] n_rnd;
    logic        r_v0, r_v1, r_v2, r_v3;
    logic [29:0] r_th;
    logic [61:0] r_prod;
    logic [31:0] r_tq;
    logic [32:0] r_q1_0, r_q2_0, r_q1_1, r_q2_1, r_q1_2, r_q2_2;
    logic [1:0]  r_neg0, r_neg1, r_neg2;
    t_root       r_root;

    assign n_t   = (37'(TWO_F - i_item.n) << 30) - 37'(i_item.frac);
    assign n_rnd = 63'(r_prod) + (63'(1) << 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th   <= n_t[35:6];
            r_q1_0 <= i_item.q1;
            r_q2_0 <= i_item.q2;
            r_neg0 <= {i_item.neg2, i_item.neg1};
            r_prod <= 62'(r_th) * 62'(LN2_Q32);
            r_q1_1 <= r_q1_0;
            r_q2_1 <= r_q2_0;
            r_neg1 <= r_neg0;
            r_tq   <= n_rnd[62:31];
            r_q1_2 <= r_q1_1;
            r_q2_2 <= r_q2_1;
            r_neg2 <= r_neg1;
            r_root.neg1 <= r_neg2[0];
            r_root.neg2 <= r_neg2[1];
            r_root.v1   <= 64'(65'(r_q1_2) * 65'(r_tq));
            r_root.v2   <= 64'(65'(r_q2_2) * 65'(r_tq));
            r_root.r1   <= '0;
            r_root.r2   <= '0;
        end
    end

    assign o_vld  = r_v3;
    assign o_root = r_root;

endmodule

### rtl/core/gpg_root.sv
// ----------------------------------------------------------------------------
// gpg_root
// One stage of the square root chain, one result bit for each coordinate.
// ----------------------------------------------------------------------------
module gpg_root #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  gpg_pkg::t_root i_root,
    output logic           o_vld,
    output gpg_pkg::t_root o_root
);
    import gpg_pkg::*;

    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

    logic [63:0] s1, s2;
    t_root       n_root;
    logic        r_vld;
    t_root       r_root;

    always_comb begin
        n_root = i_root;
        s1 = i_root.r1 + BIT;
        s2 = i_root.r2 + BIT;
        if (i_root.v1 >= s1) begin
            n_root.v1 = i_root.v1 - s1;
            n_root.r1 = (i_root.r1 >> 1) + BIT;
        end else begin
            n_root.r1 = i_root.r1 >> 1;
        end
        if (i_root.v2 >= s2) begin
            n_root.v2 = i_root.v2 - s2;
            n_root.r2 = (i_root.r2 >> 1) + BIT;
        end else begin
            n_root.r2 = i_root.r2 >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
        end
    end

    assign o_vld  = r_vld;
    assign o_root = r_root;

endmodule

### rtl/core/gpg_out.sv
// ----------------------------------------------------------------------------
// gpg_out
// Scales by the deviation, adds the mean, saturates and sends the two samples
// of a pair one after the other. Also produces the pipeline advance enable.
// ----------------------------------------------------------------------------
module gpg_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  gpg_pkg::t_root        i_root,
    input  logic signed [23:0]    i_mean,
    input  logic [23:0]           i_std,
    output logic                  o_en,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [31:0]           o_tdata,
    output logic                  o_tlast
);
    import gpg_pkg::*;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    logic        r_v0, r_v1;
    logic [56:0] r_raw1, r_raw2;
    logic [1:0]  r_neg;
    logic [31:0] r_s1, r_s2;
    logic [57:0] rnd1, rnd2;
    logic signed [33:0] val1, val2;
    logic [31:0] n_s1, n_s2;
    logic        free, take;

    logic        r_ovld, r_olast, r_pend;
    logic [31:0] r_odata, r_hold;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > SAT_HI) return 32'h7FFF_FFFF;
        if (v < SAT_LO) return 32'h8000_0000;
        return v[31:0];
    endfunction

    always_comb begin
        rnd1 = 58'(r_raw1) + (58'(1) << 27);
        rnd2 = 58'(r_raw2) + (58'(1) << 27);
        val1 = r_neg[0] ? 34'(i_mean) - $signed({4'b0, rnd1[57:28]})
                        : 34'(i_mean) + $signed({4'b0, rnd1[57:28]});
        val2 = r_neg[1] ? 34'(i_mean) - $signed({4'b0, rnd2[57:28]})
                        : 34'(i_mean) + $signed({4'b0, rnd2[57:28]});
        n_s1 = sat32(val1);
        n_s2 = sat32(val2);
    end

    // The output register is free once it is empty or its sample leaves and
    // no second sample is waiting behind it.
    assign free = !r_ovld || (i_tready && !r_pend);
    assign o_en = !r_v1 || free;
    assign take = r_v1 && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (o_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_raw1 <= 57'(i_root.r1[32:0]) * 57'(i_std);
            r_raw2 <= 57'(i_root.r2[32:0]) * 57'(i_std);
            r_neg  <= {i_root.neg2, i_root.neg1};
            r_s1   <= n_s1;
            r_s2   <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_pend <= 1'b0;
        end else if (take) begin
            r_ovld <= 1'b1;
            r_pend <= 1'b1;
        end else if (r_ovld && i_tready) begin
            r_ovld <= r_pend;
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_odata <= r_s1;
            r_olast <= 1'b0;
            r_hold  <= r_s2;
        end else if (r_ovld && i_tready) begin
            r_odata <= r_hold;
            r_olast <= 1'b1;
        end
    end

    assign o_tvalid = r_ovld;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

    a_pend_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_ovld) else $error("second sample pending without output");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && i_tready && !r_olast |=> r_ovld && r_olast)
        else $error("first sample not followed by its partner");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> !r_pend) else $error("new pair loaded over a pending sample");

endmodule

### rtl/core/polar_gaussian_sample_generator.sv
// ----------------------------------------------------------------------------
// polar_gaussian_sample_generator
// Polar-method Gaussian generator: one uniform pair in, two samples out for a
// pair inside the unit circle other than its center, none otherwise.
//
//   Channel   Dir  Payload                                  Transaction when
//   s (i_s_*) in   tdata: uniform_a, uniform_b (low first)  tvalid & tready
//   m (o_m_*) out  tdata: gauss_sample; tlast: last_of_pair tvalid & tready
//   cfg       in   index 0 mean_value, 1 std_deviation      i_cfg_we
//
// An input transaction is taken every cycle while the stages advance; each
// accepted pair leaves as two samples on the single output port, which sets
// the rate of a stream of accepted pairs.
// All stages advance on one enable; a stall on the output freezes them.
// Reset (synchronous, active low) clears all valid bits and loads the mean and
// deviation registers with their reset values; data registers are not reset.
// ----------------------------------------------------------------------------
module polar_gaussian_sample_generator #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // uniform_a [UNIFORM_BITS-1:0], uniform_b above it, zero padding on top
    input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]        i_s_tdata,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // gauss_sample [31:0]
    output logic [31:0]                                o_m_tdata,
    output logic                                       o_m_tlast,
    input  logic                                       i_cfg_we,
    input  logic                                       i_cfg_idx,
    input  logic [23:0]                                i_cfg_data
);
    import gpg_pkg::*;

    localparam int FX = (UNIFORM_BITS > 30) ? 30 : UNIFORM_BITS;

    logic signed [23:0] r_mean;
    logic [23:0]        r_std;
    logic               en;

    logic  f_vld;
    t_item f_item;
    logic  s_vld  [DIV_STEPS+1];
    t_item s_item [DIV_STEPS+1];
    logic  t_vld;
    t_root t_rt;
    logic  q_vld  [ROOT_STEPS+1];
    t_root q_rt   [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= MEAN_RESET;
            r_std  <= STD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAN: r_mean <= $signed(i_cfg_data);
                CFG_STD:  r_std  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign o_s_tready = en;

    gpg_front #(.UB(UNIFORM_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_ua    (i_s_tdata[UNIFORM_BITS-1:0]),
        .i_ub    (i_s_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS]),
        .o_vld   (f_vld),
        .o_item  (f_item)
    );

    assign s_vld[0]  = f_vld;
    assign s_item[0] = f_item;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        gpg_step #(.STEP(k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (s_vld[k]),
            .i_item  (s_item[k]),
            .o_vld   (s_vld[k+1]),
            .o_item  (s_item[k+1])
        );
    end

    gpg_tail #(.FRAC_X(FX)) u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld[DIV_STEPS]),
        .i_item  (s_item[DIV_STEPS]),
        .o_vld   (t_vld),
        .o_root  (t_rt)
    );

    assign q_vld[0] = t_vld;
    assign q_rt[0]  = t_rt;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        gpg_root #(.STEP(k)) u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (q_vld[k]),
            .i_root  (q_rt[k]),
            .o_vld   (q_vld[k+1]),
            .o_root  (q_rt[k+1])
        );
    end

    gpg_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld[ROOT_STEPS]),
        .i_root   (q_rt[ROOT_STEPS]),
        .i_mean   (r_mean),
        .i_std    (r_std),
        .o_en     (en),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

### test/polar_gaussian_sample_generator_test.sv
// ----------------------------------------------------------------------------
// polar_gaussian_sample_generator_test
// Drives uniform pairs into the polar Gaussian generator and compares every
// sample with a bit-exact fixed-point prediction, under random gaps and
// stalls on both streams and several mean and deviation settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polar_gaussian_sample_generator_test;
    import gpg_pkg::*;

    localparam int UB = 16;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [31:0] sample;
        logic        last;
    } t_sample;

    // Keeps the current settings and the samples still owed by the block.
    class sample_scoreboard;
        logic signed [23:0] mean;
        logic [23:0]        std_dev;
        t_sample            pending[$];
        int                 errors;

        function void set_defaults();
            mean    = MEAN_RESET;
            std_dev = STD_RESET;
        endfunction

        function longint map_word(logic [15:0] u);
            return longint'({u, 1'b0}) - 64'sd65536;
        endfunction

        function logic [63:0] neg2ln(logic [63:0] w);
            int          n;
            logic [63:0] m, fr, t, prod;
            n = 0;
            for (int k = 0; k < 64; k++) if (w[k]) n = k;
            m = (n <= 30) ? (w << (30 - n)) : (w >> (n - 30));
            fr = 0;
            for (int i = 0; i < 30; i++) begin
                m = (m * m) >> 30;
                fr = fr << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    fr[0] = 1'b1;
                end
            end
            t = (64'(32 - n) << 30) - fr;
            prod = (t >> 6) * 64'(LN2_Q32);
            return (prod + (64'd1 << 30)) >> 31;
        endfunction

        function logic [63:0] ratio(logic [63:0] num, logic [63:0] den);
            logic [63:0] rem, q;
            rem = num;
            q = 0;
            if (rem >= den) begin
                rem -= den;
                q = 1;
            end
            for (int i = 0; i < 32; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem -= den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [31:0] sample_of(longint d, logic [63:0] w, logic [63:0] tq);
            logic [63:0] ad, y, mag;
            longint      val;
            ad = (d < 0) ? 64'(-d) : 64'(d);
            y = root(ratio(ad * ad, w) * tq);
            mag = (y * 64'(std_dev) + (64'd1 << 27)) >> 28;
            val = (d < 0) ? longint'(mean) - longint'(mag) : longint'(mean) + longint'(mag);
            if (val > 64'sd2147483647) val = 64'sd2147483647;
            if (val < -64'sd2147483648) val = -64'sd2147483648;
            return val[31:0];
        endfunction

        function void note_pair(logic [15:0] ua, logic [15:0] ub);
            longint      d1, d2;
            logic [63:0] w, tq;
            t_sample     s;
            d1 = map_word(ua);
            d2 = map_word(ub);
            w = 64'(d1 * d1 + d2 * d2);
            if (w == 0 || w >= (64'd1 << 32)) return;
            tq = neg2ln(w);
            s.sample = sample_of(d1, w, tq);
            s.last = 1'b0;
            pending = {pending, s};
            s.sample = sample_of(d2, w, tq);
            s.last = 1'b1;
            pending = {pending, s};
        endfunction

        task automatic report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task automatic check_sample(logic [31:0] data, logic last);
            t_sample e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected sample %h", data));
                return;
            end
            e = pending.pop_front();
            if (data !== e.sample)
                report($sformatf("sample %h, predicted %h", data, e.sample));
            if (last !== e.last)
                report($sformatf("last %b, predicted %b", last, e.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_MEAN;
    logic [23:0] i_cfg_data = '0;

    sample_scoreboard sb = new();
    int  hold_cycles = 0;
    bit  stim_done = 1'b0;

    polar_gaussian_sample_generator #(.UNIFORM_BITS(UB)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("polar_gaussian_sample_generator test failed");
        $finish;
    end

    task automatic write_reg(logic idx, logic [23:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MEAN) sb.mean = value;
        else sb.std_dev = value;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // The valid stays high between back-to-back transactions.
    task automatic send_pair(logic [15:0] ua, logic [15:0] ub, bit gaps);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ub, ua};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_pair(ua, ub);
    endtask

    // A pair strictly inside the unit circle and off its center, with random content.
    task automatic send_inside(bit gaps);
        logic [15:0] ua, ub;
        longint      d1, d2;
        do begin
            ua = 16'($urandom);
            ub = 16'($urandom);
            d1 = sb.map_word(ua);
            d2 = sb.map_word(ub);
        end while (d1 * d1 + d2 * d2 >= 64'sd4294967296 || (d1 == 0 && d2 == 0));
        send_pair(ua, ub, gaps);
    endtask

    // Receiver: random stalls, a long hold-off when asked.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) sb.check_sample(o_m_tdata, o_m_tlast);
    end

    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stim_done || $urandom_range(0, 4) == 0) wait_n = 0;
            if (wait_n > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [23:0] means[5];
        logic [23:0] stds[5];
        sb.set_defaults();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs at reset settings: edges, zero coordinates, rejects.
        send_pair(16'h8000, 16'h8000, 1'b0);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'h8000, 16'hFFFF, 1'b0);
        send_pair(16'h0001, 16'h8000, 1'b0);
        send_pair(16'h8001, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h8001, 16'h8001, 1'b0);
        send_pair(16'hC000, 16'h4000, 1'b0);
        send_pair(16'hB505, 16'hB504, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'h2000, 16'h8000, 1'b0);
        wait_idle();

        // Extreme settings, including ones that saturate.
        means = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h123456, 24'hF00000};
        stds  = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000001, 24'h001000};
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_MEAN, means[p]);
            write_reg(CFG_STD, stds[p]);
            send_pair(16'h8001, 16'h8000, 1'b0);
            send_pair(16'hFFFF, 16'h8000, 1'b0);
            send_pair(16'h0001, 16'h0001, 1'b0);
            for (int i = 0; i < 150; i++) begin
                if (i == 50) hold_cycles = 300;
                if ($urandom_range(0, 4) == 0) send_pair(16'($urandom), 16'($urandom), 1'b1);
                else send_inside((i >= 50 && i < 100) ? 1'b0 : 1'b1);
            end
            // Sender pauses until every sample has come back.
            wait_idle();
            write_reg(CFG_MEAN, 24'($urandom));
            write_reg(CFG_STD, 24'($urandom_range(0, 65535)));
            for (int i = 0; i < 75; i++) begin
                if ($urandom_range(0, 4) == 0) send_pair(16'($urandom), 16'($urandom), 1'b1);
                else send_inside(1'b1);
            end
            wait_idle();
        end

        stim_done = 1'b1;
        for (int c = 0; c < 100000 && sb.pending.size() != 0; c++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d samples never came", sb.pending.size()));
        if (sb.errors == 0) begin
            $display("polar_gaussian_sample_generator test passed");
        end else begin
            $display("polar_gaussian_sample_generator test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/gpg_pkg.sv
rtl/core/gpg_front.sv
rtl/core/gpg_step.sv
rtl/core/gpg_tail.sv
rtl/core/gpg_root.sv
rtl/core/gpg_out.sv
rtl/core/polar_gaussian_sample_generator.sv
test/polar_gaussian_sample_generator_test.sv
